// ===== rtl/five_stage_pipeline_core_defines.svh =====
// Assertion macros for the five-stage pipeline core checker.
// Used by fsp_checker only; no other dependencies.
`ifndef FIVE_STAGE_PIPELINE_CORE_DEFINES_SVH
`define FIVE_STAGE_PIPELINE_CORE_DEFINES_SVH

// Clocked assertion, muted while reset is held.
`define FSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion on the contents of a result beat that is being offered.
`define FSP_ASSERT_OUT(lbl, prop, msg) \
  `FSP_ASSERT(lbl, out_tvalid |-> (prop), msg)

`endif

// ===== rtl/fsp_pkg.sv =====
// Shared types, opcodes and decode helpers for the five-stage pipeline core.
// No dependencies.
package fsp_pkg;

  typedef enum logic [2:0] {
    MODE_LOAD_INSTR = 3'd0,
    MODE_LOAD_DATA  = 3'd1,
    MODE_SET_REG    = 3'd2,
    MODE_STEP       = 3'd3,
    MODE_READ_REG   = 3'd4,
    MODE_READ_DATA  = 3'd5
  } mode_t;

  localparam logic [5:0] OPC_LW    = 6'h23;
  localparam logic [5:0] OPC_SW    = 6'h2B;
  localparam logic [5:0] OPC_BEQ   = 6'h04;
  localparam logic [5:0] OPC_RTYPE = 6'h00;

  localparam logic [3:0] FN_ADD = 4'h0;
  localparam logic [3:0] FN_SUB = 4'h2;
  localparam logic [3:0] FN_AND = 4'h4;
  localparam logic [3:0] FN_OR  = 4'h5;
  localparam logic [3:0] FN_SLT = 4'hA;

  localparam logic [1:0] FWD_REG = 2'd0;
  localparam logic [1:0] FWD_EXM = 2'd1;
  localparam logic [1:0] FWD_MWB = 2'd2;

  typedef struct packed {
    logic regdst;
    logic aluop1;
    logic aluop0;
    logic alusrc;
    logic branch;
    logic memread;
    logic memwrite;
    logic regwrite;
    logic memtoreg;
  } ctl_t;

  typedef struct packed {
    logic       aluop1;
    logic       aluop0;
    logic [3:0] fn;
  } alu_ctl_t;

  function automatic ctl_t decode_ctl(input logic [31:0] w);
    ctl_t c;
    c = '0;
    if (w != 32'd0) begin
      case (w[31:26])
        OPC_RTYPE: begin
          c.regwrite = 1'b1;
          c.aluop1   = 1'b1;
          c.regdst   = 1'b1;
        end
        OPC_LW: begin
          c.memtoreg = 1'b1;
          c.regwrite = 1'b1;
          c.memread  = 1'b1;
          c.alusrc   = 1'b1;
        end
        OPC_SW: begin
          c.memwrite = 1'b1;
          c.alusrc   = 1'b1;
        end
        OPC_BEQ: begin
          c.branch = 1'b1;
          c.aluop0 = 1'b1;
        end
        default: c = '0;
      endcase
    end
    return c;
  endfunction

endpackage

// ===== rtl/fsp_alu.sv =====
// Execute-stage ALU of the five-stage pipeline core.
// Depends on fsp_pkg for the ALU control struct and funct codes.
module fsp_alu import fsp_pkg::*; (
  input  alu_ctl_t    ctl,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  always_comb begin
    if (!ctl.aluop0 && !ctl.aluop1) begin
      y = a + b;
    end else if (ctl.aluop0) begin
      y = a - b;
    end else begin
      case (ctl.fn)
        FN_ADD:  y = a + b;
        FN_SUB:  y = a - b;
        FN_AND:  y = a & b;
        FN_OR:   y = a | b;
        FN_SLT:  y = {31'd0, $signed(a) < $signed(b)};
        default: y = 32'hFFFF_FFFF;
      endcase
    end
  end

endmodule

// ===== rtl/five_stage_pipeline_core.sv =====
// Channel  Dir  Beat                              Ports
// in       in   mode, address, value (command)    in_tvalid/in_tready/in_tdata
// out      out  pc, hazard flags, writeback, read out_tvalid/out_tready/out_tdata
//
// One beat per clock while in_tready is high; each gives one result next cycle.
// A step advances the five stages; IF and ID hold on a load-use stall.
// Instruction memory has a registered read kept pointed at the current pc.
// rst_n (sync) clears pipeline state and the valid bits of both memories.
// in_tready drops only while a result beat waits on out_tready.
// Top level of the five-stage pipeline core; depends on fsp_pkg and fsp_alu.
module five_stage_pipeline_core import fsp_pkg::*; #(
  parameter int IMEM_WORDS = 128,
  parameter int DMEM_WORDS = 32,
  parameter int REG_COUNT  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // mode[2:0], address[9:3], value[41:10]
  output logic        out_tvalid,
  input  logic        out_tready,
  // pc[8:0], stall_res[9], branch_taken[10], forward_a[12:11], forward_b[14:13],
  // wb_valid[15], wb_reg[20:16], wb_value[52:21], read_value[84:53]
  output logic [87:0] out_tdata
);

  localparam int IW  = $clog2(IMEM_WORDS);
  localparam int PCW = IW + 2;
  localparam int DW  = $clog2(DMEM_WORDS);
  localparam int RW  = $clog2(REG_COUNT);

  function automatic logic wr_ok(input logic [6:0] n);
    return (n != 7'd0) && (32'(n) < REG_COUNT);
  endfunction

  // command fields
  logic        in_acc, step;
  mode_t       mode;
  logic [6:0]  addr;
  logic [31:0] val, a32;
  assign in_acc = in_tvalid && in_tready;
  assign mode   = mode_t'(in_tdata[2:0]);
  assign addr   = in_tdata[9:3];
  assign val    = in_tdata[41:10];
  assign a32    = 32'(addr);
  assign step   = in_acc && (mode == MODE_STEP);

  // pipeline registers
  logic [PCW-1:0] pc_r, pc_nxt;
  logic [31:0]    fdw_r, fdw_nxt;
  logic [31:0]    ide_a_r, ide_b_r, ide_imm_r;
  logic [4:0]     ide_rs_r, ide_rt_r, ide_rd_r;
  ctl_t           ide_ctl_r;
  logic [5:0]     ide_fn_r;
  logic [31:0]    exm_res_r, exm_sd_r;
  ctl_t           exm_ctl_r;
  logic [4:0]     exm_dst_r;
  logic [31:0]    mwb_ld_r, mwb_res_r;
  logic           mwb_regwr_r, mwb_m2r_r;
  logic [4:0]     mwb_dst_r;

  logic [31:0] rf_r [REG_COUNT];

  // WB
  logic [31:0] wdata;
  logic        wfwd, mfwd;
  assign wdata = mwb_m2r_r ? mwb_ld_r : mwb_res_r;
  assign wfwd  = mwb_regwr_r && wr_ok({2'b00, mwb_dst_r});
  assign mfwd  = exm_ctl_r.regwrite && wr_ok({2'b00, exm_dst_r});

  // MEM address check
  logic          d_inr;
  logic [DW-1:0] d_idx;
  assign d_inr = !exm_res_r[31] && (32'(exm_res_r[31:2]) < DMEM_WORDS);
  assign d_idx = exm_res_r[DW+1:2];

  // EX with forwarding
  logic [1:0]  fa, fb;
  logic [31:0] opa, opb, alu_y;
  logic [4:0]  edst;
  alu_ctl_t    actl;
  always_comb begin
    fa  = FWD_REG;
    fb  = FWD_REG;
    opa = ide_a_r;
    opb = ide_b_r;
    if (mfwd && exm_dst_r == ide_rs_r) begin
      fa  = FWD_EXM;
      opa = exm_res_r;
    end else if (wfwd && mwb_dst_r == ide_rs_r) begin
      fa  = FWD_MWB;
      opa = wdata;
    end
    if (mfwd && exm_dst_r == ide_rt_r) begin
      fb  = FWD_EXM;
      opb = exm_res_r;
    end else if (wfwd && mwb_dst_r == ide_rt_r) begin
      fb  = FWD_MWB;
      opb = wdata;
    end
  end
  assign actl = '{aluop1: ide_ctl_r.aluop1, aluop0: ide_ctl_r.aluop0, fn: ide_fn_r[3:0]};
  assign edst = ide_ctl_r.regdst ? ide_rd_r : ide_rt_r;

  fsp_alu u_alu (
    .ctl (actl),
    .a   (opa),
    .b   (ide_ctl_r.alusrc ? ide_imm_r : opb),
    .y   (alu_y)
  );

  // ID
  logic [4:0]  rs, rt, rd;
  logic [15:0] imm16;
  logic [31:0] imm_sx, boff, ra, rb;
  ctl_t        dctl;
  logic        stall_c, taken;
  assign rs     = fdw_r[25:21];
  assign rt     = fdw_r[20:16];
  assign rd     = fdw_r[15:11];
  assign imm16  = fdw_r[15:0];
  assign imm_sx = {{16{imm16[15]}}, imm16};
  assign boff   = {imm_sx[29:0], 2'b00};
  assign dctl   = decode_ctl(fdw_r);
  assign stall_c = ide_ctl_r.memread && (ide_rt_r == rs || ide_rt_r == rt);

  // register reads see this cycle's writeback
  always_comb begin
    if (wfwd && mwb_dst_r == rs)    ra = wdata;
    else if (wr_ok({2'b00, rs}))    ra = rf_r[rs[RW-1:0]];
    else                            ra = 32'd0;
    if (wfwd && mwb_dst_r == rt)    rb = wdata;
    else if (wr_ok({2'b00, rt}))    rb = rf_r[rt[RW-1:0]];
    else                            rb = 32'd0;
  end
  assign taken = !stall_c && dctl.branch && (ra == rb);

  // IF: imem read data always holds the word at pc_r
  logic [31:0]           imem [IMEM_WORDS];
  logic [IMEM_WORDS-1:0] ivld_r;
  logic [31:0]           ird_r, ifw;
  logic                  ird_v_r, imem_we;
  logic [IW-1:0]         iwa, ira;
  assign imem_we = in_acc && (mode == MODE_LOAD_INSTR) && (a32 < IMEM_WORDS);
  assign iwa     = a32[IW-1:0];
  assign ira     = pc_nxt[PCW-1:2];
  assign ifw     = ird_v_r ? ird_r : 32'd0;

  always_comb begin
    pc_nxt  = pc_r;
    fdw_nxt = fdw_r;
    if (step && !stall_c) begin
      if (taken) begin
        pc_nxt  = pc_r + boff[PCW-1:0];
        fdw_nxt = 32'd0;
      end else begin
        pc_nxt  = pc_r + PCW'(4);
        fdw_nxt = ifw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (imem_we) imem[iwa] <= val;
    if (imem_we && iwa == ira) ird_r <= val;
    else                       ird_r <= imem[ira];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r  <= '0;
      ird_v_r <= 1'b0;
    end else begin
      if (imem_we) ivld_r[iwa] <= 1'b1;
      ird_v_r <= (imem_we && iwa == ira) ? 1'b1 : ivld_r[ira];
    end
  end

  // pipeline latches
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      fdw_r       <= '0;
      ide_a_r     <= '0;
      ide_b_r     <= '0;
      ide_imm_r   <= '0;
      ide_rs_r    <= '0;
      ide_rt_r    <= '0;
      ide_rd_r    <= '0;
      ide_ctl_r   <= '0;
      ide_fn_r    <= '0;
      exm_res_r   <= '0;
      exm_sd_r    <= '0;
      exm_ctl_r   <= '0;
      exm_dst_r   <= '0;
      mwb_res_r   <= '0;
      mwb_regwr_r <= 1'b0;
      mwb_m2r_r   <= 1'b0;
      mwb_dst_r   <= '0;
    end else begin
      pc_r  <= pc_nxt;
      fdw_r <= fdw_nxt;
      if (step) begin
        mwb_res_r   <= exm_res_r;
        mwb_regwr_r <= exm_ctl_r.regwrite;
        mwb_m2r_r   <= exm_ctl_r.memtoreg;
        mwb_dst_r   <= exm_dst_r;
        exm_res_r   <= alu_y;
        exm_sd_r    <= opb;
        exm_ctl_r   <= ide_ctl_r;
        exm_dst_r   <= edst;
        ide_a_r     <= ra;
        ide_b_r     <= rb;
        ide_imm_r   <= imm_sx;
        ide_rs_r    <= rs;
        ide_rt_r    <= rt;
        ide_rd_r    <= rd;
        ide_ctl_r   <= stall_c ? ctl_t'('0) : dctl;
        ide_fn_r    <= fdw_r[5:0];
      end
    end
  end

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_r <= '{default: '0};
    end else if (in_acc && mode == MODE_SET_REG && wr_ok(addr)) begin
      rf_r[a32[RW-1:0]] <= val;
    end else if (step && wfwd) begin
      rf_r[mwb_dst_r[RW-1:0]] <= wdata;
    end
  end

  // data memory: write port, load read port, command read port
  logic [31:0]           dmem [DMEM_WORDS];
  logic [DMEM_WORDS-1:0] dvld_r;
  logic                  dwe, cmd_dinr;
  logic [DW-1:0]         dwa, cmd_didx;
  logic [31:0]           dwd, rreg;
  assign cmd_dinr = a32 < DMEM_WORDS;
  assign cmd_didx = a32[DW-1:0];
  always_comb begin
    dwe = 1'b0;
    dwa = cmd_didx;
    dwd = val;
    if (in_acc && mode == MODE_LOAD_DATA && cmd_dinr) begin
      dwe = 1'b1;
    end else if (step && exm_ctl_r.memwrite && d_inr) begin
      dwe = 1'b1;
      dwa = d_idx;
      dwd = exm_sd_r;
    end
  end
  assign rreg = wr_ok(addr) ? rf_r[a32[RW-1:0]] : 32'd0;

  logic [31:0] out_rdv_r;
  always_ff @(posedge clk) begin
    if (dwe) dmem[dwa] <= dwd;
    if (step) begin
      mwb_ld_r <= (exm_ctl_r.memread && d_inr && dvld_r[d_idx]) ? dmem[d_idx] : 32'd0;
    end
    if (in_acc) begin
      if (mode == MODE_READ_DATA)
        out_rdv_r <= (cmd_dinr && dvld_r[cmd_didx]) ? dmem[cmd_didx] : 32'd0;
      else if (mode == MODE_READ_REG)
        out_rdv_r <= rreg;
      else
        out_rdv_r <= 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dvld_r <= '0;
    else if (dwe) dvld_r[dwa] <= 1'b1;
  end

  // result register
  logic        out_vld_r, out_stall_r, out_taken_r, out_wbv_r;
  logic [8:0]  out_pc_r;
  logic [1:0]  out_fa_r, out_fb_r;
  logic [4:0]  out_wbr_r;
  logic [31:0] out_wbx_r, pc32;
  assign pc32      = 32'(pc_nxt);
  assign in_tready = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (in_acc) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_pc_r    <= pc32[8:0];
      out_stall_r <= step && stall_c;
      out_taken_r <= step && taken;
      out_fa_r    <= step ? fa : FWD_REG;
      out_fb_r    <= step ? fb : FWD_REG;
      out_wbv_r   <= step && wfwd;
      out_wbr_r   <= (step && wfwd) ? mwb_dst_r : 5'd0;
      out_wbx_r   <= (step && wfwd) ? wdata : 32'd0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_rdv_r, out_wbx_r, out_wbr_r, out_wbv_r,
                       out_fb_r, out_fa_r, out_taken_r, out_stall_r, out_pc_r};

endmodule

// ===== rtl/fsp_checker.sv =====
// Port-level checker for the five-stage pipeline core, bound to the top level.
// Depends on five_stage_pipeline_core_defines.svh for the assertion macros.
`include "five_stage_pipeline_core_defines.svh"

module fsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [47:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata
);

  logic in_hs;
  assign in_hs = in_tvalid && in_tready && (in_tdata[2:0] == in_tdata[2:0]);

  `FSP_ASSERT(a_beat_gives_result, in_hs |=> out_tvalid, "accepted beat gave no result")
  `FSP_ASSERT(a_ready_only_on_wait, !in_tready |-> out_tvalid && !out_tready, "input held off with no result waiting")
  `FSP_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  `FSP_ASSERT_OUT(a_wb_zero, out_tdata[15] || out_tdata[52:16] == 37'd0, "writeback fields set without wb_valid")
  `FSP_ASSERT_OUT(a_flags_sane, !(out_tdata[9] && out_tdata[10]) && out_tdata[12:11] != 2'd3 && out_tdata[14:13] != 2'd3, "branch during stall or bad forward code")

endmodule

bind five_stage_pipeline_core fsp_checker u_fsp_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for five_stage_pipeline_core: loads programs, steps the pipeline
// and compares every result beat with a built-in pipeline predictor. Depends on fsp_pkg.
module tb_top;
  import fsp_pkg::*;

  localparam int IMEM_WORDS = 128;
  localparam int DMEM_WORDS = 32;
  localparam int REG_COUNT  = 32;
  localparam logic [31:0] PC_SPAN = IMEM_WORDS * 4;

  typedef struct packed {
    logic [31:0] value;
    logic [6:0]  address;
    logic [2:0]  mode;
  } cmd_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [31:0] wb_value;
    logic [4:0]  wb_reg;
    logic        wb_valid;
    logic [1:0]  forward_b;
    logic [1:0]  forward_a;
    logic        branch_taken;
    logic        stall_res;
    logic [8:0]  pc;
  } res_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [47:0] in_tdata;
  logic [87:0] out_tdata;

  five_stage_pipeline_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // predictor state
  logic [8:0]  pc_q;
  logic [31:0] imem [IMEM_WORDS];
  logic [31:0] dmem [DMEM_WORDS];
  logic [31:0] rf   [REG_COUNT];
  logic [31:0] ifid_w;
  logic [31:0] idex_a, idex_b, idex_imm;
  logic [4:0]  idex_rs, idex_rt, idex_rd;
  ctl_t        idex_ctl;
  logic [5:0]  idex_fn;
  logic [31:0] exm_res, exm_sd;
  ctl_t        exm_ctl;
  logic [4:0]  exm_dst;
  logic [31:0] mwb_ld, mwb_res;
  ctl_t        mwb_ctl;
  logic [4:0]  mwb_dst;

  cmd_t cmd_q[$];
  res_t expected_q[$];
  int   errors = 0;
  bit   stim_done = 0;
  bit   in_fire = 0;
  int   n_results = 0;
  int   total_cmds = 0;

  function automatic bit reg_ok(logic [4:0] n);
    return n != 0 && n < REG_COUNT;
  endfunction

  function automatic logic [31:0] alu_calc(ctl_t c, logic [5:0] fn, logic [31:0] a,
                                           logic [31:0] b);
    if (!c.aluop0 && !c.aluop1) return a + b;
    if (c.aluop0) return a - b;
    case (fn[3:0])
      FN_ADD: return a + b;
      FN_SUB: return a - b;
      FN_AND: return a & b;
      FN_OR:  return a | b;
      FN_SLT: return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      default: return '1;
    endcase
  endfunction

  function automatic ctl_t ctl_of(logic [31:0] w);
    ctl_t c;
    c = '0;
    if (w != 0)
      case (w[31:26])
        OPC_RTYPE: begin c.regwrite = 1; c.aluop1 = 1; c.regdst = 1; end
        OPC_LW: begin c.memtoreg = 1; c.regwrite = 1; c.memread = 1; c.alusrc = 1; end
        OPC_SW: begin c.memwrite = 1; c.alusrc = 1; end
        OPC_BEQ: begin c.branch = 1; c.aluop0 = 1; end
        default: c = '0;
      endcase
    return c;
  endfunction

  task automatic pipe_reset();
    pc_q = 0; ifid_w = 0;
    foreach (imem[i]) imem[i] = 0;
    foreach (dmem[i]) dmem[i] = 0;
    foreach (rf[i]) rf[i] = 0;
    idex_a = 0; idex_b = 0; idex_imm = 0; idex_rs = 0; idex_rt = 0; idex_rd = 0;
    idex_ctl = '0; idex_fn = 0;
    exm_res = 0; exm_sd = 0; exm_ctl = '0; exm_dst = 0;
    mwb_ld = 0; mwb_res = 0; mwb_ctl = '0; mwb_dst = 0;
  endtask

  task automatic predict_cmd(cmd_t c);
    res_t r;
    logic [31:0] wdata, ld, opa, opb, res, ra, rb, w, t;
    logic [4:0] edst, rs, rt;
    logic [31:0] idx;
    bit wfwd, mfwd, inr;
    ctl_t dctl;
    r = '0;
    case (c.mode)
      MODE_LOAD_INSTR: imem[c.address] = c.value;
      MODE_LOAD_DATA: if (c.address < DMEM_WORDS) dmem[c.address] = c.value;
      MODE_SET_REG: if (reg_ok(c.address[4:0]) && c.address < REG_COUNT)
                      rf[c.address[4:0]] = c.value;
      MODE_READ_REG: if (c.address < REG_COUNT && reg_ok(c.address[4:0]))
                       r.read_value = rf[c.address[4:0]];
      MODE_READ_DATA: if (c.address < DMEM_WORDS) r.read_value = dmem[c.address];
      MODE_STEP: begin
        wdata = mwb_ctl.memtoreg ? mwb_ld : mwb_res;
        wfwd = mwb_ctl.regwrite && reg_ok(mwb_dst);
        if (wfwd) begin
          rf[mwb_dst] = wdata;
          r.wb_valid = 1; r.wb_reg = mwb_dst; r.wb_value = wdata;
        end
        inr = !exm_res[31] && (exm_res >> 2) < DMEM_WORDS;
        idx = exm_res >> 2;
        ld = 0;
        if (exm_ctl.memwrite && inr) dmem[idx] = exm_sd;
        if (exm_ctl.memread && inr) ld = dmem[idx];
        mfwd = exm_ctl.regwrite && reg_ok(exm_dst);
        opa = idex_a; opb = idex_b;
        if (mfwd && exm_dst == idex_rs) begin r.forward_a = FWD_EXM; opa = exm_res; end
        else if (wfwd && mwb_dst == idex_rs) begin r.forward_a = FWD_MWB; opa = wdata; end
        if (mfwd && exm_dst == idex_rt) begin r.forward_b = FWD_EXM; opb = exm_res; end
        else if (wfwd && mwb_dst == idex_rt) begin r.forward_b = FWD_MWB; opb = wdata; end
        res = alu_calc(idex_ctl, idex_fn, opa, idex_ctl.alusrc ? idex_imm : opb);
        edst = idex_ctl.regdst ? idex_rd : idex_rt;
        w = ifid_w; rs = w[25:21]; rt = w[20:16];
        dctl = ctl_of(w);
        r.stall_res = idex_ctl.memread && (idex_rt == rs || idex_rt == rt);
        ra = reg_ok(rs) ? rf[rs] : 0;
        rb = reg_ok(rt) ? rf[rt] : 0;
        r.branch_taken = !r.stall_res && dctl.branch && ra == rb;
        mwb_ld = ld; mwb_res = exm_res; mwb_ctl = exm_ctl; mwb_dst = exm_dst;
        exm_res = res; exm_sd = opb; exm_dst = edst;
        exm_ctl = idex_ctl;
        idex_a = ra; idex_b = rb; idex_imm = {{16{w[15]}}, w[15:0]};
        idex_rs = rs; idex_rt = rt; idex_rd = w[15:11];
        idex_ctl = r.stall_res ? ctl_t'('0) : dctl;
        idex_fn = w[5:0];
        if (r.stall_res) ;
        else if (r.branch_taken) begin
          t = {23'd0, pc_q} + ({{16{w[15]}}, w[15:0]} << 2);
          pc_q = t % PC_SPAN;
          ifid_w = 0;
        end else begin
          ifid_w = imem[(pc_q >> 2) % IMEM_WORDS];
          pc_q = (pc_q + 4) % PC_SPAN;
        end
      end
      default: ;
    endcase
    r.pc = pc_q;
    expected_q.push_back(r);
  endtask

  // clock and timeout
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("five_stage_pipeline_core verification failed");
    $finish;
  end

  // driver; in_fire marks a beat taken at the last rising edge
  int in_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
    end else if (in_tvalid && !in_fire) begin
      // hold current beat
    end else begin
      cmd_t c;
      if (in_fire) in_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0;
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 0;
      end else if (cmd_q.size() > 0) begin
        c = cmd_q.pop_front();
        in_tdata <= {6'd0, c.value, c.address, c.mode};
        in_tvalid <= 1;
      end else begin
        in_tvalid <= 0;
      end
    end
  end

  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) predict_cmd(cmd_t'(in_tdata[41:0]));
  end

  // monitor
  int out_gap = 0;
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_tready <= 0;
    end else begin
      out_tready <= 1;
      if ($urandom_range(0, 3) == 0) out_gap = $urandom_range(0, 15);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      res_t got, exp_r;
      got = res_t'(out_tdata[84:0]);
      n_results++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %h", $time, got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          errors++;
          $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
        end
      end
    end
  end

  function automatic cmd_t mk(mode_t m, logic [6:0] a, logic [31:0] v);
    cmd_t c;
    c.mode = m; c.address = a; c.value = v;
    return c;
  endfunction

  function automatic logic [31:0] rnd_instr();
    logic [31:0] w;
    logic [4:0] rs, rt, rd;
    rs = $urandom_range(0, 5); rt = $urandom_range(0, 5); rd = $urandom_range(0, 5);
    w = $urandom;
    case ($urandom_range(0, 9))
      0, 1: w = {OPC_LW, rs, rt, 16'($urandom_range(0, 40) * 4)};
      2: w = {OPC_SW, rs, rt, 16'($urandom_range(0, 40) * 4)};
      3: w = {OPC_BEQ, rs, rt, 16'($signed($urandom_range(0, 8)) - 16'sd4)};
      4, 5, 6: begin
        case ($urandom_range(0, 5))
          0: w = {OPC_RTYPE, rs, rt, rd, 5'd0, 6'h20};
          1: w = {OPC_RTYPE, rs, rt, rd, 5'd0, 6'h22};
          2: w = {OPC_RTYPE, rs, rt, rd, 5'd0, 6'h24};
          3: w = {OPC_RTYPE, rs, rt, rd, 5'd0, 6'h25};
          4: w = {OPC_RTYPE, rs, rt, rd, 5'd0, 6'h2A};
          default: w = {OPC_RTYPE, rs, rt, rd, 5'd0, 6'($urandom)};
        endcase
      end
      7: w = 0;
      default: ;
    endcase
    return w;
  endfunction

  // stimulus
  initial begin
    in_tvalid = 0; in_tdata = 0; out_tready = 0; rst_n = 0;
    pipe_reset();
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n = 1;
    // directed: small program exercising forwarding, load-use stall, taken branch
    cmd_q.push_back(mk(MODE_SET_REG, 1, 32'h7FFF_FFFF));
    cmd_q.push_back(mk(MODE_SET_REG, 2, 32'h8000_0000));
    cmd_q.push_back(mk(MODE_SET_REG, 0, 32'hFFFF_FFFF));
    cmd_q.push_back(mk(MODE_LOAD_DATA, 31, 32'hDEAD_BEEF));
    cmd_q.push_back(mk(MODE_LOAD_DATA, 127, 32'h1234_5678));
    cmd_q.push_back(mk(MODE_LOAD_INSTR, 0, {OPC_RTYPE, 5'd1, 5'd2, 5'd3, 5'd0, 6'h2A}));
    cmd_q.push_back(mk(MODE_LOAD_INSTR, 1, {OPC_LW, 5'd0, 5'd4, 16'd124}));
    cmd_q.push_back(mk(MODE_LOAD_INSTR, 2, {OPC_RTYPE, 5'd4, 5'd3, 5'd5, 5'd0, 6'h20}));
    cmd_q.push_back(mk(MODE_LOAD_INSTR, 3, {OPC_SW, 5'd0, 5'd5, 16'hFFFC}));
    cmd_q.push_back(mk(MODE_LOAD_INSTR, 4, {OPC_BEQ, 5'd0, 5'd0, 16'hFFFB}));
    cmd_q.push_back(mk(MODE_LOAD_INSTR, 127, 32'hFC00_0000));
    for (int i = 0; i < 10; i++) cmd_q.push_back(mk(MODE_STEP, 0, 0));
    cmd_q.push_back(mk(MODE_READ_REG, 5, 0));
    cmd_q.push_back(mk(MODE_READ_DATA, 31, 0));
    cmd_q.push_back(mk(MODE_READ_DATA, 127, 0));
    cmd_q.push_back(mk(mode_t'(3'd7), 7'h7F, 32'hFFFF_FFFF));
    // random: mostly programs followed by step runs, some noise
    while (cmd_q.size() < 1000) begin
      if ($urandom_range(0, 3) == 0) begin
        cmd_q.push_back(mk(mode_t'($urandom_range(0, 7)), 7'($urandom), $urandom));
      end else begin
        for (int i = 0; i < 4; i++)
          cmd_q.push_back(mk(MODE_SET_REG, 7'($urandom_range(0, 6)),
                             $urandom_range(0, 1) ? $urandom : $urandom_range(0, 64)));
        for (int i = 0; i < 6; i++)
          cmd_q.push_back(mk(MODE_LOAD_INSTR, 7'($urandom), rnd_instr()));
        cmd_q.push_back(mk(MODE_LOAD_DATA, 7'($urandom_range(0, 40)), $urandom));
        for (int i = 0; i < 20; i++) cmd_q.push_back(mk(MODE_STEP, 7'($urandom), $urandom));
        cmd_q.push_back(mk(MODE_READ_REG, 7'($urandom_range(0, 40)), 0));
        cmd_q.push_back(mk(MODE_READ_DATA, 7'($urandom_range(0, 40)), 0));
      end
    end
    total_cmds = cmd_q.size();
    wait (n_results == total_cmds);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0 && n_results == total_cmds)
      $display("five_stage_pipeline_core verification clean");
    else
      $display("five_stage_pipeline_core verification failed");
    $finish;
  end
endmodule
